/* rtl/scba_pkg.sv */
package scba_pkg;

  localparam int NUM_CLASSES = 10;
  localparam int MIN_SHIFT = 4;
  localparam int STACK_DEPTH = 256;
  localparam int ARENA_CHUNKS = 128;
  localparam int CHUNK_SHIFT = 13;
  localparam int CLS_W = 4;
  localparam int PTR_W = 8;
  localparam int CNT_W = 9;
  localparam int ENTRY_W = 16;
  localparam int ADDR_W = 20;
  localparam int FRESH_W = 8;
  localparam int MEM_AW = CLS_W + PTR_W;
  localparam logic [16:0] TOP_BYTES = 17'd8192;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_OOM = 3'd1;
  localparam logic [2:0] ST_LARGE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO = 3'd4;

  localparam logic [0:0] REG_CHUNK_LIMIT = 1'b0;

  // Class of a size in 1..8192: ceil(log2(size)) - 4, and 0 for sizes up to 16.
  function automatic logic [CLS_W-1:0] class_of(input logic [15:0] size);
    logic [15:0] s;
    logic [CLS_W-1:0] c;
    begin
      s = size - 16'd1;
      c = '0;
      for (int b = MIN_SHIFT; b < MIN_SHIFT + NUM_CLASSES - 1; b++) begin
        if (s[b]) c = CLS_W'(b - MIN_SHIFT + 1);
      end
      return c;
    end
  endfunction

endpackage

/* rtl/size_class_block_allocator.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata: operation, request_size, block_address, new_size
// m_axis    | out       | tdata: granted_address, status, fits_in_place
// apb       | in        | chunk_limit at address 0
//
// Free, query and every status-only case go from the accept straight to S_DONE,
// which loads the output register. An allocate from a free stack passes S_READ,
// since the stack read is registered, then S_SPLIT, where the single write port
// takes one push per cycle, then S_DONE. A fresh chunk skips the read. Reset
// clears the fill counts and the fresh-chunk pointer; no clearing pass.
// A finished result waits in S_DONE while the output register still holds the
// previous one; a new transaction is taken only in S_IDLE.
module size_class_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] operation, [17:2] request_size, [37:18] block_address, [53:38] new_size
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] granted_address, [22:20] status, [23] fits_in_place
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SPLIT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  logic [7:0] chunk_limit;
  logic [CNT_W-1:0] fill [NUM_CLASSES];
  logic [FRESH_W-1:0] next_fresh;
  logic [ENTRY_W-1:0] mem [2**MEM_AW];
  logic [ENTRY_W-1:0] rd_data;

  logic [CLS_W-1:0] want, cur;
  logic [ADDR_W-1:0] blk;
  logic out_valid;
  logic [23:0] out_data;
  logic [23:0] res_data;

  logic [1:0]  in_op;
  logic [15:0] in_size, in_nsize;
  logic [ADDR_W-1:0] in_addr;
  assign in_op    = s_axis_tdata[1:0];
  assign in_size  = s_axis_tdata[17:2];
  assign in_addr  = s_axis_tdata[37:18];
  assign in_nsize = s_axis_tdata[53:38];

  logic wr_en;
  logic [MEM_AW-1:0] wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic rd_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Smallest non-empty class at or above the wanted class.
  logic found;
  logic [CLS_W-1:0] pick, in_cls;
  logic [7:0] limit;
  always_comb begin
    in_cls = class_of(in_size);
    found = 1'b0;
    pick = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (CLS_W'(c) >= in_cls && fill[c] != '0) begin
        found = 1'b1;
        pick = CLS_W'(c);
      end
    end
    limit = (chunk_limit > 8'(ARENA_CHUNKS)) ? 8'(ARENA_CHUNKS) : chunk_limit;
  end

  logic accept, in_zero, in_large, n_large;
  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_zero = (in_size == 16'd0);
  assign in_large = ({1'b0, in_size} > TOP_BYTES);
  assign n_large = ({1'b0, in_nsize} > TOP_BYTES);

  logic alloc_ok, alloc_pop, alloc_fresh, free_push;
  assign alloc_ok = (in_op == OP_ALLOC) && !in_zero && !in_large;
  assign alloc_pop = alloc_ok && found;
  assign alloc_fresh = alloc_ok && !found && (next_fresh < limit);
  assign free_push = (in_op == OP_FREE) && !in_zero && !in_large &&
                     (fill[in_cls] < CNT_W'(STACK_DEPTH));

  // Status and fit answer of the accepted transaction, before any split.
  logic [2:0] idle_status;
  logic idle_fits;
  always_comb begin
    idle_status = ST_OK;
    idle_fits = 1'b0;
    unique case (in_op)
      OP_ALLOC: begin
        if (in_zero) idle_status = ST_ZERO;
        else if (in_large) idle_status = ST_LARGE;
        else if (!alloc_pop && !alloc_fresh) idle_status = ST_OOM;
      end
      OP_FREE: begin
        if (in_zero) idle_status = ST_ZERO;
        else if (in_large) idle_status = ST_LARGE;
        else if (!free_push) idle_status = ST_FULL;
      end
      OP_QUERY: begin
        if (in_large || n_large) idle_status = ST_LARGE;
        else if (in_zero || in_nsize == 16'd0)
          idle_fits = in_zero && (in_nsize == 16'd0);
        else idle_fits = (in_cls == class_of(in_nsize));
      end
      default: idle_status = ST_OK;
    endcase
  end

  logic [CLS_W-1:0] nxt;
  assign nxt = cur - CLS_W'(1);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en = 1'b0;
    rd_addr = {pick, fill[pick][PTR_W-1:0] - PTR_W'(1)};
    if (state == S_IDLE && accept)
      rd_en = alloc_pop;
    if (state == S_IDLE && accept && free_push) begin
      wr_en = 1'b1;
      wr_addr = {in_cls, fill[in_cls][PTR_W-1:0]};
      wr_data = ENTRY_W'(in_addr >> MIN_SHIFT);
    end
    if (state == S_SPLIT && cur > want) begin
      wr_en = 1'b1;
      wr_addr = {nxt, fill[nxt][PTR_W-1:0]};
      wr_data = ENTRY_W'((blk + (ADDR_W'(1) << (32'(nxt) + MIN_SHIFT))) >> MIN_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      next_fresh <= '0;
      chunk_limit <= 8'd128;
      for (int c = 0; c < NUM_CLASSES; c++) fill[c] <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == {REG_CHUNK_LIMIT, 2'b00})
        chunk_limit <= pwdata[7:0];
      if (state == S_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
        out_data <= res_data;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_data <= {idle_fits, idle_status, 20'd0};
            want <= in_cls;
            if (alloc_pop) begin
              fill[pick] <= fill[pick] - CNT_W'(1);
              cur <= pick;
              state <= S_READ;
            end else if (alloc_fresh) begin
              blk <= ADDR_W'({12'd0, next_fresh} << CHUNK_SHIFT);
              next_fresh <= next_fresh + FRESH_W'(1);
              cur <= CLS_W'(NUM_CLASSES - 1);
              state <= S_SPLIT;
            end else begin
              if (free_push) fill[in_cls] <= fill[in_cls] + CNT_W'(1);
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          blk <= ADDR_W'({rd_data, 4'd0});
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          if (cur > want) begin
            fill[nxt] <= fill[nxt] + CNT_W'(1);
            cur <= nxt;
          end else begin
            res_data <= {1'b0, ST_OK, blk};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;
  assign prdata = (paddr == {REG_CHUNK_LIMIT, 2'b00}) ? {24'd0, chunk_limit} : 32'd0;
  assign pready = 1'b1;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_axis_tready)
    else $error("item taken while busy");
  a_fresh: assert property (@(posedge clk) disable iff (rst)
    next_fresh <= 8'(ARENA_CHUNKS))
    else $error("fresh chunk pointer past arena");
`endif
endmodule

/* tb/size_class_block_allocator_tb.sv */
`timescale 1ns / 100ps

module size_class_block_allocator_tb;
  import scba_pkg::*;

  typedef struct packed {
    logic [19:0] granted;
    logic [2:0]  status;
    logic        fits;
  } alloc_result_t;

  typedef struct {
    logic [1:0]    op;
    logic [15:0]   size;
    logic [19:0]   addr;
    logic [15:0]   nsize;
    bit            typed;
    alloc_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  size_class_block_allocator u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow allocator state.
  logic [15:0] free_stack [NUM_CLASSES][STACK_DEPTH];
  int unsigned fill_count [NUM_CLASSES];
  int unsigned fresh_chunk;
  int unsigned chunk_limit_q;

  alloc_result_t pending_results[$];
  logic [19:0]   live_addr[$];
  logic [15:0]   live_size[$];
  int            error_count = 0;
  bit            no_gaps = 1'b0;

  function automatic int unsigned size_class(input logic [15:0] size);
    int unsigned c;
    c = 0;
    while (c < NUM_CLASSES - 1 && (32'd16 << c) < size) c++;
    return c;
  endfunction

  task automatic push_free(input int unsigned cls, input logic [19:0] addr, output bit ok);
    ok = (fill_count[cls] < STACK_DEPTH);
    if (ok) begin
      free_stack[cls][fill_count[cls]] = addr[19:4];
      fill_count[cls]++;
    end
  endtask

  task automatic predict_allocator(input logic [1:0] op, input logic [15:0] size,
                                   input logic [19:0] addr, input logic [15:0] nsize,
                                   output alloc_result_t r);
    int unsigned want_cls, i, lim;
    logic [19:0] blk;
    bit have, ok;
    r = '0;
    r.status = ST_OK;
    have = 1'b0;
    blk = '0;
    if (op == OP_ALLOC) begin
      if (size == 0) r.status = ST_ZERO;
      else if ({1'b0, size} > TOP_BYTES) r.status = ST_LARGE;
      else begin
        want_cls = size_class(size);
        i = want_cls;
        lim = (chunk_limit_q < ARENA_CHUNKS) ? chunk_limit_q : ARENA_CHUNKS;
        while (i < NUM_CLASSES && fill_count[i] == 0) i++;
        if (i < NUM_CLASSES) begin
          fill_count[i]--;
          blk = {free_stack[i][fill_count[i]], 4'b0};
          have = 1'b1;
        end else if (fresh_chunk < lim) begin
          blk = 20'(fresh_chunk << CHUNK_SHIFT);
          fresh_chunk++;
          i = NUM_CLASSES - 1;
          have = 1'b1;
        end else begin
          r.status = ST_OOM;
        end
        if (have) begin
          while (i > want_cls) begin
            i--;
            push_free(i, 20'(blk + (20'd16 << i)), ok);
          end
          r.granted = blk;
          live_addr.push_back(blk);
          live_size.push_back(size);
        end
      end
    end else if (op == OP_FREE) begin
      if (size == 0) r.status = ST_ZERO;
      else if ({1'b0, size} > TOP_BYTES) r.status = ST_LARGE;
      else begin
        push_free(size_class(size), addr, ok);
        if (!ok) r.status = ST_FULL;
      end
    end else if (op == OP_QUERY) begin
      if ({1'b0, size} > TOP_BYTES || {1'b0, nsize} > TOP_BYTES) r.status = ST_LARGE;
      else if (size == 0 || nsize == 0) r.fits = (size == 0 && nsize == 0);
      else r.fits = (size_class(size) == size_class(nsize));
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_val, $realtime);
    error_count++;
  endtask

  // Result side: random backpressure and in-order comparison.
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 0);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[19:0] !== exp_r.granted)
          report_mismatch("granted_address", m_axis_tdata[19:0], exp_r.granted);
        if (m_axis_tdata[22:20] !== exp_r.status)
          report_mismatch("status", m_axis_tdata[22:20], exp_r.status);
        if (m_axis_tdata[23] !== exp_r.fits)
          report_mismatch("fits_in_place", m_axis_tdata[23], exp_r.fits);
      end
    end
    if (no_gaps) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 99) < 3) m_axis_tready <= 1'b0;
    else if (!m_axis_tready && $urandom_range(0, 9) < 2) m_axis_tready <= 1'b1;
    else if (m_axis_tready) m_axis_tready <= ($urandom_range(0, 9) < 8);
  end

  task automatic idle_gap();
    int unsigned n, pick;
    pick = $urandom_range(0, 19);
    n = no_gaps ? 0 : (pick < 12) ? 0 : (pick < 18) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 30);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_request(input stim_row_t row);
    alloc_result_t r;
    idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, row.nsize, row.addr, row.size, row.op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_allocator(row.op, row.size, row.addr, row.nsize, r);
    pending_results.push_back(row.typed ? row.want : r);
  endtask

  task automatic write_chunk_limit(input logic [7:0] value);
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_CHUNK_LIMIT, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    chunk_limit_q = value;
  endtask

  function automatic stim_row_t mk(input logic [1:0] op, input logic [15:0] size,
                                   input logic [19:0] addr, input logic [15:0] nsize);
    stim_row_t row;
    row.op = op;
    row.size = size;
    row.addr = addr;
    row.nsize = nsize;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_typed(input logic [1:0] op, input logic [15:0] size,
                                         input logic [19:0] addr, input logic [15:0] nsize,
                                         input logic [19:0] g, input logic [2:0] st,
                                         input logic f);
    stim_row_t row;
    row = mk(op, size, addr, nsize);
    row.typed = 1'b1;
    row.want = '{g, st, f};
    return row;
  endfunction

  function automatic logic [15:0] random_class_size();
    int unsigned cls;
    cls = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 9);
    if (cls == 0) return 16'($urandom_range(1, 16));
    return 16'($urandom_range((8 << cls) + 1, 16 << cls));
  endfunction

  function automatic stim_row_t random_row();
    int unsigned pick, idx;
    stim_row_t row;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      row = mk(OP_ALLOC, random_class_size(), 20'($urandom), 16'($urandom));
      if ($urandom_range(0, 29) == 0) row.size = 0;
      else if ($urandom_range(0, 29) == 0) row.size = 16'($urandom_range(8193, 65535));
    end else if (pick < 80 && live_addr.size() > 0) begin
      idx = $urandom_range(0, live_addr.size() - 1);
      row = mk(OP_FREE, live_size[idx], live_addr[idx], 16'($urandom));
      live_addr.delete(idx);
      live_size.delete(idx);
    end else if (pick < 88) begin
      row = mk(OP_FREE, ($urandom_range(0, 3) == 0) ? 16'($urandom) : random_class_size(),
               20'($urandom), 16'($urandom));
    end else if (pick < 98) begin
      row = mk(OP_QUERY, random_class_size(), 20'($urandom), random_class_size());
      if ($urandom_range(0, 4) == 0) row.nsize = 16'($urandom);
      if ($urandom_range(0, 9) == 0) row.size = 16'($urandom);
    end else begin
      row = mk(2'd3, 16'($urandom), 20'($urandom), 16'($urandom));
    end
    return row;
  endfunction

  stim_row_t directed_rows[$];

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++) fill_count[c] = 0;
    fresh_chunk = 0;
    chunk_limit_q = 128;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      mk_typed(OP_ALLOC, 16'd0, 20'd0, 16'd0, 20'd0, ST_ZERO, 1'b0),
      mk_typed(OP_ALLOC, 16'd8193, 20'd0, 16'd0, 20'd0, ST_LARGE, 1'b0),
      mk_typed(OP_ALLOC, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 20'd0, ST_LARGE, 1'b0),
      mk_typed(OP_ALLOC, 16'd1, 20'd0, 16'd0, 20'd0, ST_OK, 1'b0),
      mk_typed(OP_ALLOC, 16'd8192, 20'd0, 16'd0, 20'd8192, ST_OK, 1'b0),
      mk(OP_ALLOC, 16'd16, 20'd0, 16'd0),
      mk_typed(OP_FREE, 16'd0, 20'd64, 16'd0, 20'd0, ST_ZERO, 1'b0),
      mk_typed(OP_FREE, 16'hFFFF, 20'd64, 16'd0, 20'd0, ST_LARGE, 1'b0),
      mk(OP_FREE, 16'd8192, 20'd8192, 16'd0),
      mk(OP_FREE, 16'd17, 20'hFFFFF, 16'd0),
      mk_typed(OP_QUERY, 16'd0, 20'd0, 16'd0, 20'd0, ST_OK, 1'b1),
      mk_typed(OP_QUERY, 16'd0, 20'd0, 16'd5, 20'd0, ST_OK, 1'b0),
      mk_typed(OP_QUERY, 16'd100, 20'hFFFFF, 16'd128, 20'd0, ST_OK, 1'b1),
      mk_typed(OP_QUERY, 16'd129, 20'd0, 16'd128, 20'd0, ST_OK, 1'b0),
      mk_typed(OP_QUERY, 16'd8193, 20'd0, 16'd1, 20'd0, ST_LARGE, 1'b0),
      mk_typed(OP_QUERY, 16'd1, 20'd0, 16'hFFFF, 20'd0, ST_LARGE, 1'b0),
      mk_typed(2'd3, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 20'd0, ST_OK, 1'b0),
      mk(OP_ALLOC, 16'd4096, 20'd0, 16'd0),
      mk(OP_ALLOC, 16'd8192, 20'd0, 16'd0),
      mk(OP_ALLOC, 16'd17, 20'd0, 16'd0)
    };
    foreach (directed_rows[k]) send_request(directed_rows[k]);

    // Overfill the smallest class so the full-stack refusal shows up.
    write_chunk_limit(8'd128);
    for (int k = 0; k < 270; k++) begin
      no_gaps = (k < 100);
      send_request(mk(OP_FREE, 16'($urandom_range(1, 16)), 20'($urandom), 16'($urandom)));
    end
    no_gaps = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_chunk_limit(8'd255);
        1: write_chunk_limit(8'd1);
        2: write_chunk_limit(8'd3);
        default: write_chunk_limit(8'd128);
      endcase
      for (int k = 0; k < 75; k++) begin
        no_gaps = (ph == 2 && k < 30);
        send_request(random_row());
      end
    end
    no_gaps = 1'b0;

    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (30) @(posedge clk);
    if (error_count == 0) $display("size_class_block_allocator_tb OK");
    else $display("size_class_block_allocator_tb NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("size_class_block_allocator_tb NOT OK");
    $finish;
  end

endmodule
